// ===== sv/belu_pkg.sv =====
// Shared constants, codes and control types of the Bezier envelope lookup.
`default_nettype none
package belu_pkg;

  // input item commands
  localparam logic [1:0] CMD_WR_ANCHOR = 2'd0;
  localparam logic [1:0] CMD_WR_CTRL   = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_RECT_LEFT   = 3'd0;
  localparam logic [2:0] CFG_RECT_TOP    = 3'd1;
  localparam logic [2:0] CFG_RECT_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_RECT_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_NUM_SEGS    = 3'd4;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  // micro-step counts
  localparam int BEZ_STEPS = 9;
  localparam int DIV_STEPS = 17;

  // datapath operations
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_TGT      = 5'd1;
  localparam logic [4:0] OP_SCMP     = 5'd2;
  localparam logic [4:0] OP_LDB      = 5'd3;
  localparam logic [4:0] OP_LDC      = 5'd4;
  localparam logic [4:0] OP_M_UU     = 5'd5;
  localparam logic [4:0] OP_M_UUU    = 5'd6;
  localparam logic [4:0] OP_M_UT     = 5'd7;
  localparam logic [4:0] OP_W1       = 5'd8;
  localparam logic [4:0] OP_M_TT     = 5'd9;
  localparam logic [4:0] OP_M_TTT    = 5'd10;
  localparam logic [4:0] OP_ACC0     = 5'd11;
  localparam logic [4:0] OP_ACC1     = 5'd12;
  localparam logic [4:0] OP_ACC2     = 5'd13;
  localparam logic [4:0] OP_CHECK    = 5'd14;
  localparam logic [4:0] OP_YDONE    = 5'd15;
  localparam logic [4:0] OP_DIV_INIT = 5'd16;
  localparam logic [4:0] OP_DIV_STEP = 5'd17;

  typedef struct packed {
    logic [4:0] op;
    logic       coord_y;   // curve evaluation works on y coordinates
    logic       res_load;  // load the result register
    logic       res_zero;  // result is all zero (write or unused command)
  } belu_cmd_t;

  typedef struct packed {
    logic eq;           // anchor lies exactly at the query position
    logic lt;           // anchor lies left of the query position
    logic conv;         // curve x within one pixel of the target
    logic div_trivial;  // level is zero or saturated, no division needed
    logic out_busy;     // result register still holds an untaken item
  } belu_status_t;

  // operation of each step of one cubic evaluation
  function automatic logic [4:0] bez_op(input logic [3:0] step);
    logic [4:0] op;
    case (step)
      4'd0: op = OP_M_UU;
      4'd1: op = OP_M_UUU;
      4'd2: op = OP_M_UT;
      4'd3: op = OP_W1;
      4'd4: op = OP_M_TT;
      4'd5: op = OP_M_TTT;
      4'd6: op = OP_ACC0;
      4'd7: op = OP_ACC1;
      4'd8: op = OP_ACC2;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

// ===== sv/belu_if.sv =====
// Stream interfaces of the input items and the result items.
`default_nettype none
interface belu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [4:0]  index;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic [16:0] position;

  modport source(output valid, cmd, index, point_x, point_y, position, input ready);
  modport sink(input valid, cmd, index, point_x, point_y, position, output ready);
endinterface

interface belu_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] level;
  logic [15:0] marker_x;
  logic [15:0] marker_y;
  logic        converged;

  modport source(output valid, level, marker_x, marker_y, converged, input ready);
  modport sink(input valid, level, marker_x, marker_y, converged, output ready);
endinterface
`default_nettype wire

// ===== sv/bezier_envelope_lookup_unit.sv =====
// Top level of the Bezier envelope lookup: controller plus datapath.
//
//  channel  | direction | payload                                   | handshake
//  in_ch    | in        | cmd, index, point_x, point_y, position    | valid/ready
//  out_ch   | out       | level, marker_x, marker_y, converged      | valid/ready
//  cfg_*    | in        | cfg_index, cfg_data                       | cfg_we
//
// Write items go straight to the result step. A query searches the anchors, then
// bisects in x and evaluates y unless one matches; each cubic evaluation is nine
// steps, eight of them on the one shared multiplier; the level a 17-step divide.
// One item is worked on at a time; in_ch.ready is high only while idle.
// The result register holds a finished item while out_ch stalls; the next item
// may be accepted meanwhile. Synchronous active-low reset, no clearing pass.
`default_nettype none
module bezier_envelope_lookup_unit #(
  parameter int MAX_SEGMENTS   = 16,
  parameter int MAX_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  belu_in_if.sink          in_ch,
  belu_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  localparam int AW = $clog2(MAX_SEGMENTS + 1);

  belu_pkg::belu_cmd_t    cmd;
  belu_pkg::belu_status_t st;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          n_segs;
  logic                   in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  belu_ctrl #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_cmd  (in_ch.cmd),
    .in_ready(in_ch.ready),
    .n_segs  (n_segs),
    .st      (st),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  belu_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_cmd       (in_ch.cmd),
    .in_index     (in_ch.index),
    .in_point_x   (in_ch.point_x),
    .in_point_y   (in_ch.point_y),
    .in_position  (in_ch.position),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .st           (st),
    .n_segs       (n_segs),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_level    (out_ch.level),
    .out_marker_x (out_ch.marker_x),
    .out_marker_y (out_ch.marker_y),
    .out_converged(out_ch.converged)
  );
endmodule
`default_nettype wire

// ===== sv/belu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module belu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/belu_ctrl.sv =====
// Controller: sequences anchor search, bisection, level division and result.
`default_nettype none
module belu_ctrl #(
  parameter int MAX_SEGMENTS   = 16,
  parameter int MAX_ITERATIONS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  input  wire logic [1:0]                             in_cmd,
  output logic                                        in_ready,
  input  wire logic [$clog2(MAX_SEGMENTS + 1)-1:0]    n_segs,
  input  wire belu_pkg::belu_status_t                 st,
  output belu_pkg::belu_cmd_t                         cmd,
  output logic      [$clog2(MAX_SEGMENTS + 1)-1:0]    rd_addr
);
  localparam int AW = $clog2(MAX_SEGMENTS + 1);
  localparam int KW = $clog2(MAX_ITERATIONS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TGT   = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_LDA   = 4'd4;
  localparam logic [3:0] S_LDB   = 4'd5;
  localparam logic [3:0] S_LDC   = 4'd6;
  localparam logic [3:0] S_BEZ   = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_YDONE = 4'd9;
  localparam logic [3:0] S_DINIT = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] seg_r, seg_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [3:0]    bstep_r, bstep_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;
  logic          coord_r, coord_nxt;
  logic          zero_r, zero_nxt;
  logic [AW:0]   i_inc;

  assign in_ready = (state_r == S_IDLE);
  assign i_inc    = {1'b0, i_r} + {{AW{1'b0}}, 1'b1};

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    seg_nxt      = seg_r;
    k_nxt        = k_r;
    bstep_nxt    = bstep_r;
    dcnt_nxt     = dcnt_r;
    coord_nxt    = coord_r;
    zero_nxt     = zero_r;
    cmd.op       = belu_pkg::OP_NONE;
    cmd.coord_y  = coord_r;
    cmd.res_load = 1'b0;
    cmd.res_zero = zero_r;
    rd_addr      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == belu_pkg::CMD_QUERY) begin
            zero_nxt  = 1'b0;
            state_nxt = S_TGT;
          end else begin
            zero_nxt  = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end
      S_TGT: begin
        cmd.op    = belu_pkg::OP_TGT;
        i_nxt     = '0;
        seg_nxt   = '0;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        rd_addr   = i_r;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.op = belu_pkg::OP_SCMP;
        if (st.eq) begin
          state_nxt = S_DINIT;
        end else if (st.lt) begin
          seg_nxt = i_r;
          if (i_inc < {1'b0, n_segs}) begin
            i_nxt     = i_inc[AW-1:0];
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_LDA;
          end
        end else begin
          state_nxt = S_LDA;
        end
      end
      S_LDA: begin
        rd_addr   = seg_r;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        cmd.op    = belu_pkg::OP_LDB;
        rd_addr   = seg_r + {{(AW-1){1'b0}}, 1'b1};
        state_nxt = S_LDC;
      end
      S_LDC: begin
        cmd.op    = belu_pkg::OP_LDC;
        k_nxt     = '0;
        bstep_nxt = '0;
        coord_nxt = 1'b0;
        state_nxt = S_BEZ;
      end
      S_BEZ: begin
        cmd.op = belu_pkg::bez_op(bstep_r);
        if (bstep_r == 4'(belu_pkg::BEZ_STEPS - 1)) begin
          bstep_nxt = '0;
          state_nxt = coord_r ? S_YDONE : S_CHK;
        end else begin
          bstep_nxt = bstep_r + 4'd1;
        end
      end
      S_CHK: begin
        cmd.op = belu_pkg::OP_CHECK;
        if (st.conv || (k_r == KW'(MAX_ITERATIONS - 1))) begin
          coord_nxt = 1'b1;
        end else begin
          k_nxt = k_r + {{(KW-1){1'b0}}, 1'b1};
        end
        state_nxt = S_BEZ;
      end
      S_YDONE: begin
        cmd.op    = belu_pkg::OP_YDONE;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.op   = belu_pkg::OP_DIV_INIT;
        dcnt_nxt = '0;
        state_nxt = st.div_trivial ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.op = belu_pkg::OP_DIV_STEP;
        if (dcnt_r == 5'(belu_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          dcnt_nxt = dcnt_r + 5'd1;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      seg_r   <= '0;
      k_r     <= '0;
      bstep_r <= '0;
      dcnt_r  <= '0;
      coord_r <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      seg_r   <= seg_nxt;
      k_r     <= k_nxt;
      bstep_r <= bstep_nxt;
      dcnt_r  <= dcnt_nxt;
      coord_r <= coord_nxt;
      zero_r  <= zero_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/belu_dp.sv =====
// Datapath: point stores, configuration, shared multiplier, divider, result register.
`default_nettype none
module belu_dp #(
  parameter int MAX_SEGMENTS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // accepted input item
  input  wire logic                                   in_fire,
  input  wire logic [1:0]                             in_cmd,
  input  wire logic [4:0]                             in_index,
  input  wire logic [15:0]                            in_point_x,
  input  wire logic [15:0]                            in_point_y,
  input  wire logic [16:0]                            in_position,
  // configuration
  input  wire logic                                   cfg_we,
  input  wire logic [2:0]                             cfg_index,
  input  wire logic [11:0]                            cfg_data,
  // controller
  input  wire belu_pkg::belu_cmd_t                    cmd,
  input  wire logic [$clog2(MAX_SEGMENTS + 1)-1:0]    rd_addr,
  output belu_pkg::belu_status_t                      st,
  output logic      [$clog2(MAX_SEGMENTS + 1)-1:0]    n_segs,
  // result register
  input  wire logic                                   out_ready,
  output logic                                        out_valid,
  output logic      [16:0]                            out_level,
  output logic      [15:0]                            out_marker_x,
  output logic      [15:0]                            out_marker_y,
  output logic                                        out_converged
);
  localparam int AW = $clog2(MAX_SEGMENTS + 1);
  localparam int CW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  // configuration registers
  logic [11:0] left_r, top_r, width_r, height_r;
  logic [4:0]  nseg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= 12'd0;
      top_r    <= 12'd0;
      width_r  <= 12'd256;
      height_r <= 12'd256;
      nseg_r   <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        belu_pkg::CFG_RECT_LEFT:   left_r   <= cfg_data;
        belu_pkg::CFG_RECT_TOP:    top_r    <= cfg_data;
        belu_pkg::CFG_RECT_WIDTH:  width_r  <= cfg_data;
        belu_pkg::CFG_RECT_HEIGHT: height_r <= cfg_data;
        belu_pkg::CFG_NUM_SEGS:    nseg_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // segment count clamped to 1..MAX_SEGMENTS
  always_comb begin
    if (nseg_r == 5'd0) begin
      n_segs = {{(AW-1){1'b0}}, 1'b1};
    end else if (32'(nseg_r) > MAX_SEGMENTS) begin
      n_segs = AW'(MAX_SEGMENTS);
    end else begin
      n_segs = AW'(nseg_r);
    end
  end

  // point stores
  logic        a_we, c_we;
  logic [31:0] wpoint, a_rdata, c_rdata;

  assign wpoint = {in_point_y, in_point_x};
  assign a_we = in_fire && (in_cmd == belu_pkg::CMD_WR_ANCHOR) &&
                (32'(in_index) < MAX_SEGMENTS + 1);
  assign c_we = in_fire && (in_cmd == belu_pkg::CMD_WR_CTRL) &&
                (32'(in_index) < MAX_SEGMENTS);

  belu_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS + 1)) u_anchor_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(AW'(in_index)),
    .wdata(wpoint),
    .raddr(rd_addr),
    .rdata(a_rdata)
  );

  belu_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_ctrl_ram (
    .clk  (clk),
    .we   (c_we),
    .waddr(CW'(in_index)),
    .wdata(wpoint),
    .raddr(CW'(rd_addr)),
    .rdata(c_rdata)
  );

  // working registers
  logic [16:0] pos_r;
  logic [28:0] target_r;
  logic [31:0] p0_r, c_r, p3_r;
  logic [16:0] t_r, tmin_r, tmax_r;
  logic [33:0] pa_r;
  logic [16:0] w0_r, w3_r;
  logic [17:0] w1_r;
  logic [35:0] acc_r;
  logic [15:0] y_r, mk_x_r, mk_y_r;
  logic        conv_r;
  logic [27:0] rem_r, dsh_r;
  logic [16:0] q_r;

  // shared multiplier
  logic [16:0] u;
  logic [33:0] mul_a;
  logic [17:0] mul_b;
  logic [51:0] prod;
  logic [15:0] p0c, cc, p3c;

  assign u   = belu_pkg::ONE_Q16 - t_r;
  assign p0c = cmd.coord_y ? p0_r[31:16] : p0_r[15:0];
  assign cc  = cmd.coord_y ? c_r[31:16]  : c_r[15:0];
  assign p3c = cmd.coord_y ? p3_r[31:16] : p3_r[15:0];

  always_comb begin
    case (cmd.op)
      belu_pkg::OP_TGT:   begin mul_a = {17'd0, pos_r}; mul_b = {6'd0, width_r}; end
      belu_pkg::OP_M_UU:  begin mul_a = {17'd0, u};     mul_b = {1'b0, u};       end
      belu_pkg::OP_M_UUU: begin mul_a = pa_r;           mul_b = {1'b0, u};       end
      belu_pkg::OP_M_UT:  begin mul_a = {17'd0, u};     mul_b = {1'b0, t_r};     end
      belu_pkg::OP_M_TT:  begin mul_a = {17'd0, t_r};   mul_b = {1'b0, t_r};     end
      belu_pkg::OP_M_TTT: begin mul_a = pa_r;           mul_b = {1'b0, t_r};     end
      belu_pkg::OP_ACC0:  begin mul_a = {17'd0, w0_r};  mul_b = {2'd0, p0c};     end
      belu_pkg::OP_ACC1:  begin mul_a = {16'd0, w1_r};  mul_b = {2'd0, cc};      end
      belu_pkg::OP_ACC2:  begin mul_a = {17'd0, w3_r};  mul_b = {2'd0, p3c};     end
      default:            begin mul_a = '0;             mul_b = '0;              end
    endcase
  end

  assign prod = 52'(mul_a) * 52'(mul_b);

  // anchor compare against the query position
  logic signed [16:0] dx;
  logic signed [29:0] d_ext, t_ext;
  assign dx    = $signed({1'b0, a_rdata[15:0]}) - $signed({1'b0, left_r, 4'd0});
  assign d_ext = {dx[16], dx, 12'd0};
  assign t_ext = {1'b0, target_r};

  // target x and bisection check
  logic [17:0]        rx;
  logic [15:0]        xt;
  logic signed [18:0] diff;
  logic [35:0]        w1_sum;
  assign rx     = {2'd0, left_r, 4'd0} + {1'b0, target_r[28:12]};
  assign xt     = acc_r[31:16];
  assign diff   = $signed({1'b0, rx}) - $signed({3'd0, xt});
  assign w1_sum = {2'd0, pa_r} + {1'b0, pa_r, 1'b0};

  // level numerator and saturation test
  logic signed [16:0] dy;
  logic [27:0]        num, hs;
  logic [11:0]        h;
  logic               nonpos, sat;
  assign dy     = $signed({1'b0, y_r}) - $signed({1'b0, top_r, 4'd0});
  assign nonpos = dy[16] || (dy == 17'sd0);
  assign num    = {dy[15:0], 12'd0};
  assign h      = (height_r == 12'd0) ? 12'd1 : height_r;
  assign hs     = {h, 16'd0};
  assign sat    = num > hs;

  always_comb begin
    st.eq          = (d_ext == t_ext);
    st.lt          = (d_ext < t_ext);
    st.conv        = (diff < 19'sd16) && (diff > -19'sd16);
    st.div_trivial = nonpos || sat;
    st.out_busy    = out_valid && !out_ready;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_r <= (in_position > belu_pkg::ONE_Q16) ? belu_pkg::ONE_Q16 : in_position;
    end
    case (cmd.op)
      belu_pkg::OP_TGT: target_r <= prod[28:0];
      belu_pkg::OP_SCMP: begin
        if (st.eq) begin
          y_r    <= a_rdata[31:16];
          mk_x_r <= a_rdata[15:0];
          mk_y_r <= a_rdata[31:16];
          conv_r <= 1'b1;
        end
      end
      belu_pkg::OP_LDB: begin
        p0_r <= a_rdata;
        c_r  <= c_rdata;
      end
      belu_pkg::OP_LDC: begin
        p3_r   <= a_rdata;
        t_r    <= belu_pkg::HALF_Q16;
        tmin_r <= 17'd0;
        tmax_r <= belu_pkg::ONE_Q16;
      end
      belu_pkg::OP_M_UU:  pa_r <= prod[33:0];
      belu_pkg::OP_M_UUU: w0_r <= prod[48:32];
      belu_pkg::OP_M_UT:  pa_r <= prod[33:0];
      belu_pkg::OP_W1:    w1_r <= w1_sum[33:16];
      belu_pkg::OP_M_TT:  pa_r <= prod[33:0];
      belu_pkg::OP_M_TTT: w3_r <= prod[48:32];
      belu_pkg::OP_ACC0:  acc_r <= prod[35:0];
      belu_pkg::OP_ACC1:  acc_r <= acc_r + prod[35:0];
      belu_pkg::OP_ACC2:  acc_r <= acc_r + prod[35:0];
      belu_pkg::OP_CHECK: begin
        conv_r <= st.conv;
        if (!st.conv) begin
          if (diff > 19'sd0) begin
            tmin_r <= t_r;
            t_r    <= ((tmax_r - t_r) >> 1) + t_r;
          end else begin
            tmax_r <= t_r;
            t_r    <= t_r - ((t_r - tmin_r) >> 1);
          end
        end
      end
      belu_pkg::OP_YDONE: begin
        y_r    <= acc_r[31:16];
        mk_y_r <= acc_r[31:16];
        mk_x_r <= (rx > 18'd65535) ? 16'hFFFF : rx[15:0];
      end
      belu_pkg::OP_DIV_INIT: begin
        rem_r <= num;
        dsh_r <= hs;
        if (nonpos) begin
          q_r <= 17'd0;
        end else if (sat) begin
          q_r <= belu_pkg::ONE_Q16;
        end else begin
          q_r <= 17'd0;
        end
      end
      belu_pkg::OP_DIV_STEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[15:0], 1'b1};
        end else begin
          q_r   <= {q_r[15:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (cmd.res_zero) begin
        out_level     <= 17'd0;
        out_marker_x  <= 16'd0;
        out_marker_y  <= 16'd0;
        out_converged <= 1'b0;
      end else begin
        out_level     <= q_r;
        out_marker_x  <= mk_x_r;
        out_marker_y  <= mk_y_r;
        out_converged <= conv_r;
      end
    end
  end
endmodule
`default_nettype wire
